// ===== src/binary_morphology_5x5_unit_macros.svh =====
// Assertion macros for the binary morphology unit.
`ifndef BINARY_MORPHOLOGY_5X5_UNIT_MACROS_SVH
`define BINARY_MORPHOLOGY_5X5_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("binary morphology check failed");
`define BM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("binary morphology check failed");
`else
`define BM_ASSERT_SAME(lbl, ante, cons)
`define BM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/bmorph_pkg.sv =====
// Shared types and constants of the binary morphology unit.
package bmorph_pkg;

    localparam int DIM_W = 13;
    localparam int POS_W = DIM_W + 1;
    localparam int PIX_W = 8;
    localparam int CFG_W = 13;
    localparam int IDX_W = 2;
    localparam int WIDTH_BITS = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int MODE_BITS = 2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_DILATE = 2'd0,
        MODE_ERODE  = 2'd1,
        MODE_CLOSE  = 2'd2,
        MODE_OPEN   = 2'd3
    } mode_t;

    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [DIM_W-1:0] MIN_DIM    = 13'd5;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;

    localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

    // one pixel position moving down the stage chain
    typedef struct packed {
        logic                    vld;
        logic                    fg;
        logic signed [POS_W-1:0] row;
        logic [DIM_W-1:0]        col;
    } tok_t;

    // clamped image geometry, worked out when a register is written
    typedef struct packed {
        logic [DIM_W-1:0] w_eff;
        logic [DIM_W-1:0] w_m1;
        logic [DIM_W-1:0] w_lim;
        logic [DIM_W-1:0] h_eff;
        logic [DIM_W-1:0] h_m1;
        logic [DIM_W-1:0] h_lim;
        logic [DIM_W-1:0] cap;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             valid;
        logic             last;
    } res_t;

endpackage

// ===== src/bmorph_cell.sv =====
// One morphology stage: line memory, sliding window and position step-back.
module bmorph_cell import bmorph_pkg::*; #(
    parameter int MAX_WIDTH   = 1024,
    parameter int WINDOW_SIZE = 5
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  logic  erode,
    input  geom_t geom,
    input  tok_t  in_tok,
    output tok_t  out_tok
);

    localparam int HALF     = WINDOW_SIZE / 2;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int LINES    = WINDOW_SIZE - 1;
    localparam int WIN_BITS = WINDOW_SIZE * WINDOW_SIZE;
    localparam logic [DIM_W-1:0]        HALF_D = DIM_W'(HALF);
    localparam logic signed [POS_W-1:0] HALF_S = POS_W'(HALF);
    localparam logic signed [POS_W-1:0] ONE_S  = POS_W'(1);

    logic [LINES-1:0] line_mem [MAX_WIDTH];

    logic                    a_vld_reg;
    logic                    a_fg_reg;
    logic signed [POS_W-1:0] a_row_reg;
    logic [DIM_W-1:0]        a_col_reg;
    logic [LINES-1:0]        rd_reg;
    logic                    b_vld_reg;
    logic signed [POS_W-1:0] b_row_reg;
    logic signed [POS_W-1:0] b_row_next;
    logic [DIM_W-1:0]        b_col_reg;
    logic [DIM_W-1:0]        b_col_next;
    logic [WIN_BITS-1:0]     win_reg;
    logic [WIN_BITS-1:0]     win_next;
    logic                    interior;
    logic                    hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            win_reg   <= '0;
        end else if (adv) begin
            a_vld_reg <= in_tok.vld;
            b_vld_reg <= a_vld_reg;
            if (a_vld_reg) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_fg_reg  <= in_tok.fg;
            a_row_reg <= in_tok.row;
            a_col_reg <= in_tok.col;
            b_row_reg <= b_row_next;
            b_col_reg <= b_col_next;
        end
    end

    // column of earlier rows read into rd_reg on entry, shifted and written back as the pixel leaves the a register
    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg <= line_mem[in_tok.col[COL_W-1:0]];
            if (a_vld_reg) begin
                line_mem[a_col_reg[COL_W-1:0]] <= {rd_reg[LINES-2:0], a_fg_reg};
            end
        end
    end

    assign win_next = {win_reg[WIN_BITS-WINDOW_SIZE-1:0], rd_reg, a_fg_reg};

    always_comb begin
        if (a_col_reg < HALF_D) begin
            b_col_next = a_col_reg + geom.w_eff - HALF_D;
            b_row_next = a_row_reg - HALF_S - ONE_S;
        end else begin
            b_col_next = a_col_reg - HALF_D;
            b_row_next = a_row_reg - HALF_S;
        end
    end

    assign interior = (b_row_reg >= HALF_S)
                   && (b_row_reg <= $signed({1'b0, geom.h_lim}))
                   && (b_col_reg >= HALF_D)
                   && (b_col_reg <= geom.w_lim);
    assign hit = erode ? (&win_reg) : (|win_reg);

    assign out_tok.vld = b_vld_reg;
    assign out_tok.fg  = interior && hit;
    assign out_tok.row = b_row_reg;
    assign out_tok.col = b_col_reg;

endmodule

// ===== src/binary_morphology_5x5_unit.sv =====
// Top level of the streaming 5x5 binary morphology unit.
// Each pixel passes the a and b registers of both stages, then the output register.
// Throughput: one pixel per cycle while the skid slot is empty; each stage reads and writes
// its line memory once per pixel, on different cycles, so the line memory never stalls back-to-back pixels.
// Reset (synchronous, active low) clears counters, configuration, valid flags and windows,
// including the output/skid valid flags; line memories and data registers are not cleared.
`include "binary_morphology_5x5_unit_macros.svh"
module binary_morphology_5x5_unit import bmorph_pkg::*; #(
    parameter int MAX_WIDTH   = 1024,
    parameter int WINDOW_SIZE = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_pixel,
    input  logic             s_start_of_frame,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_out_pixel,
    output logic             m_out_valid,
    output logic             m_out_last
);

    localparam int HALF = WINDOW_SIZE / 2;
    localparam logic [DIM_W-1:0] HALF_D  = DIM_W'(HALF);
    localparam logic [DIM_W-1:0] ONE_D   = DIM_W'(1);
    localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] PAD_D   = DIM_W'(2 * HALF + 2);
    localparam logic [DIM_W-1:0] RST_W_EFF = (RST_WIDTH > MAX_W_D) ? MAX_W_D : RST_WIDTH;
    localparam logic signed [POS_W-1:0] ZERO_S = '0;
    localparam geom_t GEOM_RST = '{
        w_eff: RST_W_EFF,
        w_m1:  RST_W_EFF - ONE_D,
        w_lim: RST_W_EFF - ONE_D - HALF_D,
        h_eff: RST_HEIGHT,
        h_m1:  RST_HEIGHT - ONE_D,
        h_lim: RST_HEIGHT - ONE_D - HALF_D,
        cap:   RST_HEIGHT + PAD_D
    };

    mode_t            mode_reg;
    mode_t            mode_next;
    geom_t            geom_reg;
    geom_t            geom_next;
    logic [DIM_W-1:0] w_in;
    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_in;
    logic [DIM_W-1:0] h_clamp;

    logic             acc;
    logic             adv;
    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;
    logic [DIM_W-1:0] row0;
    logic [DIM_W-1:0] col0;
    logic [DIM_W-1:0] row1;
    logic [DIM_W-1:0] pr;
    logic [DIM_W-1:0] pc;
    logic [DIM_W-1:0] pc_inc;

    tok_t tok_in;
    tok_t c1_out;
    tok_t c2_out;
    tok_t dly_reg [2];
    tok_t fin;
    logic erode1;
    logic two_stage;
    res_t res;

    res_t out_reg;
    res_t skid_reg;
    logic m_valid_reg;
    logic skid_vld_reg;

    // configuration
    assign w_in = DIM_W'(cfg_wr_data[WIDTH_BITS-1:0]);
    assign h_in = DIM_W'(cfg_wr_data[HEIGHT_BITS-1:0]);
    assign w_clamp = (w_in < MIN_DIM) ? MIN_DIM : ((w_in > MAX_W_D) ? MAX_W_D : w_in);
    assign h_clamp = (h_in < MIN_DIM) ? MIN_DIM : ((h_in > MAX_HEIGHT) ? MAX_HEIGHT : h_in);

    always_comb begin
        mode_next = mode_reg;
        geom_next = geom_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE: begin
                    mode_next = mode_t'(cfg_wr_data[MODE_BITS-1:0]);
                end
                REG_WIDTH: begin
                    geom_next.w_eff = w_clamp;
                    geom_next.w_m1  = w_clamp - ONE_D;
                    geom_next.w_lim = w_clamp - ONE_D - HALF_D;
                end
                REG_HEIGHT: begin
                    geom_next.h_eff = h_clamp;
                    geom_next.h_m1  = h_clamp - ONE_D;
                    geom_next.h_lim = h_clamp - ONE_D - HALF_D;
                    geom_next.cap   = h_clamp + PAD_D;
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_DILATE;
            geom_reg <= GEOM_RST;
        end else begin
            mode_reg <= mode_next;
            geom_reg <= geom_next;
        end
    end

    // raster position of the incoming pixel
    assign acc = s_valid && s_ready;
    assign row0 = s_start_of_frame ? '0 : row_reg;
    assign col0 = s_start_of_frame ? '0 : col_reg;

    always_comb begin
        if (col0 >= geom_reg.w_eff) begin
            pc   = '0;
            row1 = row0 + ONE_D;
        end else begin
            pc   = col0;
            row1 = row0;
        end
        pr     = (row1 > geom_reg.cap) ? geom_reg.cap : row1;
        pc_inc = pc + ONE_D;
        if (pc_inc >= geom_reg.w_eff) begin
            col_next = '0;
            row_next = (pr < geom_reg.cap) ? (pr + ONE_D) : pr;
        end else begin
            col_next = pc_inc;
            row_next = pr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign tok_in.vld = acc;
    assign tok_in.fg  = (pr < geom_reg.h_eff) && (s_pixel != PIX_BG);
    assign tok_in.row = $signed({1'b0, pr});
    assign tok_in.col = pc;

    // stage chain
    assign erode1    = (mode_reg == MODE_ERODE) || (mode_reg == MODE_OPEN);
    assign two_stage = (mode_reg == MODE_CLOSE) || (mode_reg == MODE_OPEN);

    bmorph_cell #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_cell_first (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .erode   (erode1),
        .geom    (geom_reg),
        .in_tok  (tok_in),
        .out_tok (c1_out)
    );

    bmorph_cell #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_cell_second (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .erode   (!erode1),
        .geom    (geom_reg),
        .in_tok  (c1_out),
        .out_tok (c2_out)
    );

    // single-stage results wait alongside the second stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_reg[0] <= c1_out;
            dly_reg[1] <= dly_reg[0];
        end
    end

    assign fin = two_stage ? c2_out : dly_reg[1];

    always_comb begin
        res.valid = (fin.row >= ZERO_S) && (fin.row < $signed({1'b0, geom_reg.h_eff}));
        res.last  = res.valid && (fin.row == $signed({1'b0, geom_reg.h_m1}))
                 && (fin.col == geom_reg.w_m1);
        res.pixel = (res.valid && fin.fg) ? PIX_FG : PIX_BG;
    end

    // output register with skid slot
    assign adv     = !skid_vld_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= c2_out.vld;
            end
        end else if (c2_out.vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            out_reg <= skid_vld_reg ? skid_reg : res;
        end else if (adv && c2_out.vld) begin
            skid_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_pixel = out_reg.pixel;
    assign m_out_valid = out_reg.valid;
    assign m_out_last  = out_reg.last;

    `BM_ASSERT_SAME(a_skid_behind_out, skid_vld_reg, m_valid_reg)
    `BM_ASSERT_SAME(a_fg_only_inside, m_valid && (m_out_pixel != PIX_BG), m_out_valid && (m_out_pixel == PIX_FG))
    `BM_ASSERT_NEXT(a_skid_catches, m_valid_reg && !m_ready && !skid_vld_reg && c2_out.vld, skid_vld_reg)

endmodule
